// File: design/flce_pkg.sv
package flce_pkg;

    // Configuration register indexes
    localparam logic CFG_MESSAGE_TYPE = 1'b0;
    localparam logic CFG_CREATE_MODE  = 1'b1;

    // Message type codes
    localparam logic [1:0] MSG_COMMAND = 2'd0;
    localparam logic [1:0] MSG_CLOCK   = 2'd1;
    localparam logic [1:0] MSG_FULL    = 2'd2;

    localparam logic [1:0] MESSAGE_TYPE_RESET = MSG_FULL;

    // One input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in;

    // One result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       checksum_slot;
        logic       slot_mismatch;
        logic       message_end;
        logic       message_valid;
        logic       beyond_end;
    } t_out;

    // Framing and sum state carried from byte to byte
    typedef struct packed {
        logic [7:0] running_sum;
        logic [3:0] column_index;
        logic [4:0] line_index;
        logic       error_seen;
        logic       message_done;
    } t_state;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [1:0] message_type;
        logic       create_mode;
    } t_cfg;

endpackage

// File: design/flce_core.sv
module flce_core #(
    parameter int COMMAND_BYTES = 6,
    parameter int LINE_BYTES    = 9,
    parameter int TIMER_LINES   = 4,
    parameter int ASTRO_LINES   = 12
) (
    input  flce_pkg::t_state i_state,
    input  flce_pkg::t_in    i_data,
    input  flce_pkg::t_cfg   i_cfg,
    output flce_pkg::t_out   o_result,
    output flce_pkg::t_state o_state
);

    localparam logic [3:0] CMD_LAST  = 4'(COMMAND_BYTES - 1);
    localparam logic [3:0] LINE_LAST = 4'(LINE_BYTES - 1);
    localparam logic [4:0] FULL_LAST = 5'(2 + TIMER_LINES + ASTRO_LINES - 1);

    flce_pkg::t_state s;
    logic [3:0]       col_last;
    logic [4:0]       line_last;
    logic             slot;
    logic             mismatch;
    logic             at_end;
    logic [7:0]       ob;

    // Clear state on the first byte of a message
    always_comb begin
        s = i_state;
        if (i_data.first_byte) begin
            s = '0;
        end
    end

    // Locate the byte within its line and the message
    always_comb begin
        col_last = (s.line_index == 5'd0) ? CMD_LAST : LINE_LAST;
        case (i_cfg.message_type)
            flce_pkg::MSG_COMMAND: line_last = 5'd0;
            flce_pkg::MSG_CLOCK:   line_last = 5'd1;
            default:               line_last = FULL_LAST;
        endcase
        slot   = (s.column_index == col_last);
        at_end = slot && (s.line_index == line_last);
    end

    // Check or fill the slot, advance the sum and position
    always_comb begin
        mismatch = 1'b0;
        ob       = i_data.data_byte;
        o_state  = s;
        o_result = '0;
        if (s.message_done) begin
            o_result.out_byte   = i_data.data_byte;
            o_result.beyond_end = 1'b1;
        end else begin
            if (slot) begin
                if (i_cfg.create_mode) begin
                    ob = s.running_sum;
                end else begin
                    mismatch = (i_data.data_byte != s.running_sum);
                end
            end
            o_state.running_sum = s.running_sum + ob;
            o_state.error_seen  = s.error_seen | mismatch;
            if (slot) begin
                o_state.column_index = 4'd0;
                o_state.line_index   = s.line_index + 5'd1;
            end else begin
                o_state.column_index = s.column_index + 4'd1;
            end
            o_state.message_done   = at_end;
            o_result.out_byte      = ob;
            o_result.checksum_slot = slot;
            o_result.slot_mismatch = mismatch;
            o_result.message_end   = at_end;
            o_result.message_valid = at_end && !o_state.error_seen;
        end
    end

endmodule

// File: design/flce_obuf.sv
module flce_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  flce_pkg::t_out i_data,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output flce_pkg::t_out o_data
);

    logic           r_main_v;
    logic           r_skid_v;
    flce_pkg::t_out r_main;
    flce_pkg::t_out r_skid;
    logic           pop;

    assign o_valid = r_main_v;
    assign o_data  = r_main;
    assign o_ready = !r_skid_v;
    assign pop     = r_main_v && i_ready;

    // Hold a result in the skid stage while the main stage stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_main   <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
                r_main   <= i_data;
            end
        end else if (i_push) begin
            if (!r_main_v) begin
                r_main_v <= 1'b1;
                r_main   <= i_data;
            end else begin
                r_skid_v <= 1'b1;
                r_skid   <= i_data;
            end
        end
    end

endmodule

// File: design/framed_line_checksum_engine.sv
// Framed line checksum engine: 8-bit additive checksum over a radio
// programming message, one byte per request.
// Input channel: i_in_valid / o_in_ready carry a data byte and a
// first_byte flag that restarts the message. Output channel:
// o_out_valid / i_out_ready carry one result per input byte: the byte
// (or the computed checksum at a slot in create mode) and its flags.
// Configuration: i_cfg_we writes register i_cfg_index (0 message type,
// 1 create mode); write only while no request is in flight.
// Each result is registered in the output buffer when its byte is accepted.
// Throughput: one byte per cycle while o_in_ready is high; the sum, compare
// and position update sit in one combinational stage between the state and
// result registers. When the receiver stalls, a two-entry output buffer
// holds results and o_in_ready drops only once both entries are full.
// Reset clears the sum, position and flags, empties the output buffer,
// and sets message type to full message and create mode to verify.
module framed_line_checksum_engine #(
    parameter int COMMAND_BYTES = 6,
    parameter int LINE_BYTES    = 9,
    parameter int TIMER_LINES   = 4,
    parameter int ASTRO_LINES   = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  flce_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output flce_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [1:0]     i_cfg_data
);

    flce_pkg::t_state r_state;
    flce_pkg::t_state n_state;
    flce_pkg::t_cfg   r_cfg;
    flce_pkg::t_out   result;
    logic             push;

    assign push = i_in_valid && o_in_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.message_type <= flce_pkg::MESSAGE_TYPE_RESET;
            r_cfg.create_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                flce_pkg::CFG_MESSAGE_TYPE: r_cfg.message_type <= i_cfg_data;
                default:                    r_cfg.create_mode  <= i_cfg_data[0];
            endcase
        end
    end

    flce_core #(
        .COMMAND_BYTES (COMMAND_BYTES),
        .LINE_BYTES    (LINE_BYTES),
        .TIMER_LINES   (TIMER_LINES),
        .ASTRO_LINES   (ASTRO_LINES)
    ) u_core (
        .i_state  (r_state),
        .i_data   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (result),
        .o_state  (n_state)
    );

    // Advance the framing state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (push) begin
            r_state <= n_state;
        end
    end

    flce_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // A byte past the message end leaves the state untouched
    a_beyond_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && r_state.message_done && !i_in_data.first_byte |=> $stable(r_state))
        else $error("state changed on a byte past the message end");

    // An empty output side always takes a request
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output buffer");

    // A message ends only on a checksum slot, never on an ignored byte
    a_end_on_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.message_end |->
            o_out_data.checksum_slot && !o_out_data.beyond_end)
        else $error("message end outside a checksum slot");

    // After a message end the next byte without restart is ignored
    a_done_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && result.message_end |=> r_state.message_done)
        else $error("done flag not set after message end");

endmodule
